>>> rtl/core/qte_pkg.sv
package qte_pkg;

  // Defaults for the top-level parameters
  localparam int NUM_BINS_DEF      = 18;
  localparam int FRACTION_BITS_DEF = 14;

  // Field widths
  localparam int TAG_W  = 4;
  localparam int QUAT_W = 16;
  localparam int BIN_W  = 5;

  // Internal datapath widths
  localparam int PROD_W = 2 * QUAT_W;   // one component product
  localparam int DW     = 66;           // atan2 operand width
  localparam int ZW     = 34;           // binary angle, 2^32 is one turn
  localparam int SW     = 32;           // sine with 30 fraction bits
  localparam int NW     = 62;           // square root radicand and root

  // Pipeline shape
  localparam int CORDIC_STEPS = 30;
  localparam int NORM_STEPS   = 6;
  localparam int NORM_TOP     = 52;
  localparam int SQRT_STEPS   = 31;
  localparam int ATAN_LAT     = 1 + NORM_STEPS + 1 + CORDIC_STEPS + 1;
  localparam int SQRT_LAT     = 1 + SQRT_STEPS;

  localparam logic signed [ZW-1:0] HALF_Z = ZW'(64'sh8000_0000);
  localparam logic signed [ZW-1:0] QTR_Z  = ZW'(64'sh4000_0000);

  // One CORDIC vector in flight, with the axis shortcut carried beside it
  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 spec;
    logic                 xz;
    logic signed [ZW-1:0] sz;
  } qte_cvec_t;

  // Finished angle; xz marks an operand x of exactly zero
  typedef struct packed {
    logic signed [ZW-1:0] z;
    logic                 xz;
  } qte_ang_t;

  typedef struct packed {
    qte_ang_t roll;
    qte_ang_t yaw;
  } qte_pair_t;

  // Arctangent of 2^-i as a binary angle
  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051D;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2E;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2F9;
      5'd15:   v = 32'h0000517C;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A2F;
      5'd19:   v = 32'h00000517;
      5'd20:   v = 32'h0000028B;
      5'd21:   v = 32'h00000145;
      5'd22:   v = 32'h000000A2;
      5'd23:   v = 32'h00000051;
      5'd24:   v = 32'h00000028;
      5'd25:   v = 32'h00000014;
      5'd26:   v = 32'h0000000A;
      5'd27:   v = 32'h00000005;
      5'd28:   v = 32'h00000002;
      5'd29:   v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/qte_if.sv
interface qte_in_if import qte_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [TAG_W-1:0]         device_id;
  logic signed [QUAT_W-1:0] quat_w;
  logic signed [QUAT_W-1:0] quat_x;
  logic signed [QUAT_W-1:0] quat_y;
  logic signed [QUAT_W-1:0] quat_z;

  modport source (output valid, device_id, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink   (input valid, device_id, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_out_if import qte_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [TAG_W-1:0] device_tag;
  logic [BIN_W-1:0] roll_bin;
  logic [BIN_W-1:0] pitch_bin;
  logic [BIN_W-1:0] yaw_bin;

  modport source (output valid, device_tag, roll_bin, pitch_bin, yaw_bin, input ready);
  modport sink   (input valid, device_tag, roll_bin, pitch_bin, yaw_bin, output ready);
endinterface

>>> rtl/core/quaternion_to_euler_bins_unit.sv
// Quaternion to binned Euler angles. Takes one sample per cycle unless the output stalls; the
// pitch path is the longest one: product and sum stages, a 32-stage square root (radicand plus
// 31 root steps), then a 39-stage atan2 (1 entry, 6 normalize, 1 quarter-turn, 30 CORDIC,
// 1 clamp), and one bin register. Roll and yaw run their atan2 pipes in parallel and wait in a
// delay line. A full-output stall holds the whole pipeline.
module quaternion_to_euler_bins_unit import qte_pkg::*; #(
  parameter int NUM_BINS      = NUM_BINS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  qte_in_if.sink    in_ch,
  qte_out_if.source out_ch
);

  localparam int L = 2 + SQRT_LAT + ATAN_LAT + 1;
  localparam logic [7:0] NB = 8'(NUM_BINS);

  logic                 adv;
  logic                 vld_r [0:L-1];
  logic [TAG_W-1:0]     tag_r [0:L-1];
  logic signed [DW-1:0] roll_y, roll_x, yaw_y, yaw_x;
  logic signed [SW-1:0] sin_a, sin_b;
  logic [NW-1:0]        cos_b;
  qte_ang_t             roll_a, yaw_a, pitch_a;
  qte_pair_t            dl_r [0:SQRT_LAT-1];
  logic [BIN_W-1:0]     roll_bin_r, pitch_bin_r, yaw_bin_r;

  // Advance whenever the output register is free or being drained
  assign adv         = !vld_r[L-1] || out_ch.ready;
  assign in_ch.ready = adv;

  qte_prep #(.FRACTION_BITS(FRACTION_BITS)) u_prep (
    .clk(clk), .adv(adv),
    .qw(in_ch.quat_w), .qx(in_ch.quat_x), .qy(in_ch.quat_y), .qz(in_ch.quat_z),
    .roll_y(roll_y), .roll_x(roll_x), .yaw_y(yaw_y), .yaw_x(yaw_x), .sin_q30(sin_a)
  );

  qte_atan2 u_roll (.clk(clk), .adv(adv), .y_i(roll_y), .x_i(roll_x), .res_o(roll_a));
  qte_atan2 u_yaw  (.clk(clk), .adv(adv), .y_i(yaw_y),  .x_i(yaw_x),  .res_o(yaw_a));

  qte_isqrt u_sqrt (.clk(clk), .adv(adv), .sin_i(sin_a), .cos_o(cos_b), .sin_o(sin_b));

  qte_atan2 u_pitch (
    .clk(clk), .adv(adv),
    .y_i(DW'(sin_b)), .x_i(DW'(cos_b)), .res_o(pitch_a)
  );

  // Hold roll and yaw until pitch catches up
  always_ff @(posedge clk) begin
    if (adv) begin
      dl_r[0] <= '{roll: roll_a, yaw: yaw_a};
      for (int k = 1; k < SQRT_LAT; k++) dl_r[k] <= dl_r[k-1];
    end
  end

  // Map angles onto bins
  logic signed [ZW-1:0] p_cl;
  logic [ZW-1:0]        roll_u, yaw_u, pitch_u;
  logic [ZW+7:0]        roll_p, yaw_p, pitch_p;

  always_comb begin
    p_cl = pitch_a.z;
    if (!pitch_a.xz) begin
      if (pitch_a.z < -QTR_Z)    p_cl = -QTR_Z;
      if (pitch_a.z > QTR_Z - 1) p_cl = QTR_Z - 1;
    end
    roll_u  = ZW'(dl_r[SQRT_LAT-1].roll.z + HALF_Z);
    yaw_u   = ZW'(dl_r[SQRT_LAT-1].yaw.z + HALF_Z);
    pitch_u = ZW'(p_cl + QTR_Z);
    roll_p  = (ZW+8)'(roll_u) * (ZW+8)'(NB);
    yaw_p   = (ZW+8)'(yaw_u) * (ZW+8)'(NB);
    pitch_p = (ZW+8)'(pitch_u) * (ZW+8)'(NB);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      roll_bin_r  <= roll_p[32 +: BIN_W];
      yaw_bin_r   <= yaw_p[32 +: BIN_W];
      pitch_bin_r <= pitch_p[31 +: BIN_W];
    end
  end

  // Carry valid bits and device tags down the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < L; k++) vld_r[k] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_ch.valid;
      for (int k = 1; k < L; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag_r[0] <= in_ch.device_id;
      for (int k = 1; k < L; k++) tag_r[k] <= tag_r[k-1];
    end
  end

  assign out_ch.valid      = vld_r[L-1];
  assign out_ch.device_tag = tag_r[L-1];
  assign out_ch.roll_bin   = roll_bin_r;
  assign out_ch.pitch_bin  = pitch_bin_r;
  assign out_ch.yaw_bin    = yaw_bin_r;

endmodule

>>> rtl/core/qte_prep.sv
module qte_prep import qte_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     adv,
  input  logic signed [QUAT_W-1:0] qw,
  input  logic signed [QUAT_W-1:0] qx,
  input  logic signed [QUAT_W-1:0] qy,
  input  logic signed [QUAT_W-1:0] qz,
  output logic signed [DW-1:0]     roll_y,
  output logic signed [DW-1:0]     roll_x,
  output logic signed [DW-1:0]     yaw_y,
  output logic signed [DW-1:0]     yaw_x,
  output logic signed [SW-1:0]     sin_q30
);

  localparam logic signed [DW-1:0] ONE_Q =
    {{(DW-1){1'b0}}, 1'b1} << (2 * FRACTION_BITS);
  localparam int SH_R = (2 * FRACTION_BITS >= 30) ? 2 * FRACTION_BITS - 30 : 0;
  localparam int SH_L = (2 * FRACTION_BITS < 30) ? 30 - 2 * FRACTION_BITS : 0;

  logic signed [PROD_W-1:0] wx_r, yz_r, xx_r, yy_r, wz_r, xy_r, zz_r, wy_r, zx_r;
  logic signed [DW-1:0]     roll_y_r, roll_x_r, yaw_y_r, yaw_x_r;
  logic signed [SW-1:0]     sin_r;
  logic signed [DW-1:0]     s_raw, s_sat, s_q30;

  // Form the component products
  always_ff @(posedge clk) begin
    if (adv) begin
      wx_r <= qw * qx;
      yz_r <= qy * qz;
      xx_r <= qx * qx;
      yy_r <= qy * qy;
      wz_r <= qw * qz;
      xy_r <= qx * qy;
      zz_r <= qz * qz;
      wy_r <= qw * qy;
      zx_r <= qz * qx;
    end
  end

  // Saturate the pitch sine to one and rescale to 30 fraction bits
  always_comb begin
    s_raw = 2 * (DW'(wy_r) - DW'(zx_r));
    s_sat = s_raw;
    if (s_raw > ONE_Q)  s_sat = ONE_Q;
    if (s_raw < -ONE_Q) s_sat = -ONE_Q;
    s_q30 = (s_sat >>> SH_R) <<< SH_L;
  end

  // Form the atan2 operands
  always_ff @(posedge clk) begin
    if (adv) begin
      roll_y_r <= 2 * (DW'(wx_r) + DW'(yz_r));
      roll_x_r <= ONE_Q - 2 * (DW'(xx_r) + DW'(yy_r));
      yaw_y_r  <= 2 * (DW'(wz_r) + DW'(xy_r));
      yaw_x_r  <= ONE_Q - 2 * (DW'(yy_r) + DW'(zz_r));
      sin_r    <= SW'(s_q30);
    end
  end

  assign roll_y  = roll_y_r;
  assign roll_x  = roll_x_r;
  assign yaw_y   = yaw_y_r;
  assign yaw_x   = yaw_x_r;
  assign sin_q30 = sin_r;

endmodule

>>> rtl/core/qte_isqrt.sv
module qte_isqrt import qte_pkg::*; (
  input  logic                 clk,
  input  logic                 adv,
  input  logic signed [SW-1:0] sin_i,
  output logic [NW-1:0]        cos_o,
  output logic signed [SW-1:0] sin_o
);

  localparam logic [NW-1:0] ONE_SQ = {{(NW-1){1'b0}}, 1'b1} << 60;

  logic [NW-1:0]        n_r   [0:SQRT_STEPS];
  logic [NW-1:0]        r_r   [0:SQRT_STEPS];
  logic signed [SW-1:0] sin_r [0:SQRT_STEPS];
  logic signed [2*SW-1:0] sq;

  // Square the sine and form the radicand
  assign sq = sin_i * sin_i;

  always_ff @(posedge clk) begin
    if (adv) begin
      n_r[0]   <= ONE_SQ - NW'(sq);
      r_r[0]   <= '0;
      sin_r[0] <= sin_i;
    end
  end

  // One root bit per stage, from the top pair of bits down
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam int J = SQRT_STEPS - 1 - k;
    localparam logic [NW-1:0] BIT = {{(NW-1){1'b0}}, 1'b1} << (2 * J);
    logic [NW-1:0] t;
    logic [NW-1:0] n_nxt, r_nxt;

    always_comb begin
      t = r_r[k] + BIT;
      if (n_r[k] >= t) begin
        n_nxt = n_r[k] - t;
        r_nxt = (r_r[k] >> 1) + BIT;
      end else begin
        n_nxt = n_r[k];
        r_nxt = r_r[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        n_r[k+1]   <= n_nxt;
        r_r[k+1]   <= r_nxt;
        sin_r[k+1] <= sin_r[k];
      end
    end
  end

  assign cos_o = r_r[SQRT_STEPS];
  assign sin_o = sin_r[SQRT_STEPS];

endmodule

>>> rtl/core/qte_atan2.sv
module qte_atan2 import qte_pkg::*; (
  input  logic                 clk,
  input  logic                 adv,
  input  logic signed [DW-1:0] y_i,
  input  logic signed [DW-1:0] x_i,
  output qte_ang_t             res_o
);

  localparam int PRE = NORM_STEPS + 1;
  localparam int LAST = PRE + CORDIC_STEPS;

  qte_cvec_t     st_r  [0:LAST];
  logic [DW-1:0] mag_r [0:NORM_STEPS];
  qte_ang_t      res_r;

  qte_cvec_t            c0;
  logic signed [DW-1:0] ax, ay;

  // Catch the axes and find the larger magnitude's top bit via OR
  always_comb begin
    ax      = (x_i < 0) ? -x_i : x_i;
    ay      = (y_i < 0) ? -y_i : y_i;
    c0.x    = x_i;
    c0.y    = y_i;
    c0.z    = '0;
    c0.spec = (y_i == 0) || (x_i == 0);
    c0.xz   = (x_i == 0);
    if (y_i == 0) c0.sz = (x_i < 0) ? HALF_Z : '0;
    else          c0.sz = (y_i > 0) ? QTR_Z : -QTR_Z;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0]  <= c0;
      mag_r[0] <= ax | ay;
    end
  end

  // Normalize: shift by 32, 16, ... 1 while the shifted magnitude stays below 2^53
  for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
    localparam int S = 32 >> k;
    localparam logic [DW-1:0] LIM = {{(DW-1){1'b0}}, 1'b1} << (NORM_TOP + 1 - S);
    qte_cvec_t     v;
    logic [DW-1:0] m;

    always_comb begin
      v = st_r[k];
      m = mag_r[k];
      if (mag_r[k] < LIM) begin
        v.x = st_r[k].x <<< S;
        v.y = st_r[k].y <<< S;
        m   = mag_r[k] << S;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_r[k+1]  <= v;
        mag_r[k+1] <= m;
      end
    end
  end

  // Turn a left-half vector by a quarter turn
  qte_cvec_t pr;
  always_comb begin
    pr = st_r[NORM_STEPS];
    if (st_r[NORM_STEPS].x < 0) begin
      if (st_r[NORM_STEPS].y >= 0) begin
        pr.x = st_r[NORM_STEPS].y;
        pr.y = -st_r[NORM_STEPS].x;
        pr.z = QTR_Z;
      end else begin
        pr.x = -st_r[NORM_STEPS].y;
        pr.y = st_r[NORM_STEPS].x;
        pr.z = -QTR_Z;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) st_r[PRE] <= pr;
  end

  // Vectoring steps, one per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    localparam logic signed [ZW-1:0] T = {{(ZW-32){1'b0}}, atan_entry(5'(i))};
    qte_cvec_t            v;
    logic signed [DW-1:0] dx, dy;

    always_comb begin
      v  = st_r[PRE+i];
      dx = st_r[PRE+i].y >>> i;
      dy = st_r[PRE+i].x >>> i;
      if (st_r[PRE+i].y >= 0) begin
        v.x = st_r[PRE+i].x + dx;
        v.y = st_r[PRE+i].y - dy;
        v.z = st_r[PRE+i].z + T;
      end else begin
        v.x = st_r[PRE+i].x - dx;
        v.y = st_r[PRE+i].y + dy;
        v.z = st_r[PRE+i].z - T;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) st_r[PRE+i+1] <= v;
    end
  end

  // Clamp to one turn, or take the axis result
  qte_ang_t rn;
  always_comb begin
    rn.xz = st_r[LAST].xz;
    rn.z  = st_r[LAST].z;
    if (st_r[LAST].z < -HALF_Z)       rn.z = -HALF_Z;
    if (st_r[LAST].z > HALF_Z - 1)    rn.z = HALF_Z - 1;
    if (st_r[LAST].spec)              rn.z = st_r[LAST].sz;
  end

  always_ff @(posedge clk) begin
    if (adv) res_r <= rn;
  end

  assign res_o = res_r;

endmodule
